// ===== rtl/core/eshp_pkg.sv =====
// ----------------------------------------------------------------------------
// eshp_pkg - shared types and constants of the segment header parser
// Field widths, status codes and the entry that travels from front to back.
// ----------------------------------------------------------------------------
`default_nettype none

package eshp_pkg;

	// Table size and offset counter width
	localparam int MAX_SEGMENTS = 32;
	localparam int OFFSET_BITS  = 24;
	localparam int SEG_CNT_W    = $clog2(MAX_SEGMENTS + 1);

	// Fixed payload widths
	localparam int BYTE_W   = 8;
	localparam int KIND_W   = 1;
	localparam int IDX_W    = 5;
	localparam int ADDR_W   = 16;
	localparam int LEN_W    = 17;
	localparam int OFF_W    = 24;
	localparam int STATUS_W = 3;
	localparam int COUNT_W  = 6;

	// Header words with a meaning of their own
	localparam logic [ADDR_W-1:0] MARKER_WORD  = 16'hFFFF;
	localparam logic [ADDR_W-1:0] PADDING_WORD = 16'h1A1A;
	localparam logic [OFFSET_BITS-1:0] PAD_HEADER_BYTES = OFFSET_BITS'(4);

	// Front/back queue
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 3'd0,
		ST_PAD   = 3'd1,
		ST_SHORT = 3'd2,
		ST_FULL  = 3'd3,
		ST_RANGE = 3'd4
	} status_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_SEGMENT = 1'b0,
		KIND_STATUS  = 1'b1
	} kind_t;

	// One classified byte event: a segment record, a final status, or both
	// (record first).
	typedef struct packed {
		logic                rec_valid;
		logic [IDX_W-1:0]    seg_index;
		logic [ADDR_W-1:0]   load_addr;
		logic [LEN_W-1:0]    seg_len;
		logic [OFF_W-1:0]    data_off;
		logic                stat_valid;
		status_t             status;
		logic [OFF_W-1:0]    img_len;
		logic [COUNT_W-1:0]  seg_count;
	} entry_t;

endpackage

`default_nettype wire

// ===== rtl/core/eshp_byte_if.sv =====
// ----------------------------------------------------------------------------
// eshp_byte_if - image byte channel
// Valid/ready channel carrying one image byte and its last flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface eshp_byte_if;
	logic                      valid;
	logic                      ready;
	logic [eshp_pkg::BYTE_W-1:0] data_byte;
	logic                      is_last_byte;

	modport source (output valid, output data_byte, output is_last_byte, input ready);
	modport sink   (input valid, input data_byte, input is_last_byte, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/eshp_result_if.sv =====
// ----------------------------------------------------------------------------
// eshp_result_if - parser result channel
// Valid/ready channel carrying segment records and final status.
// ----------------------------------------------------------------------------
`default_nettype none

interface eshp_result_if;
	logic                          valid;
	logic                          ready;
	logic [eshp_pkg::KIND_W-1:0]   record_kind;
	logic [eshp_pkg::IDX_W-1:0]    segment_index;
	logic [eshp_pkg::ADDR_W-1:0]   load_address;
	logic [eshp_pkg::LEN_W-1:0]    segment_length;
	logic [eshp_pkg::OFF_W-1:0]    data_offset;
	logic [eshp_pkg::STATUS_W-1:0] parse_status;
	logic [eshp_pkg::OFF_W-1:0]    image_length;
	logic [eshp_pkg::COUNT_W-1:0]  segment_count;
	logic                          is_last_result;

	modport source (output valid, output record_kind, output segment_index,
		output load_address, output segment_length, output data_offset,
		output parse_status, output image_length, output segment_count,
		output is_last_result, input ready);
	modport sink   (input valid, input record_kind, input segment_index,
		input load_address, input segment_length, input data_offset,
		input parse_status, input image_length, input segment_count,
		input is_last_result, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/eshp_front.sv =====
// ----------------------------------------------------------------------------
// eshp_front - header parser
// Takes one byte per cycle while the queue is not full, tracks header/skip phase, classifies byte events.
// ----------------------------------------------------------------------------
`default_nettype none

module eshp_front (
	input  wire                 clk,
	input  wire                 arst_n,
	eshp_byte_if.sink           in_bytes,
	input  wire                 q_full,
	output logic                push,
	output eshp_pkg::entry_t    push_entry
);
	import eshp_pkg::*;

	typedef enum logic [1:0] {
		PH_HDR,
		PH_EXT,
		PH_SKIP,
		PH_DONE
	} phase_t;

	phase_t                  phase_q, phase_d;
	logic [1:0]              hbc_q, hbc_d;
	logic [ADDR_W-1:0]       fw_q, fw_d, sw_q, sw_d;
	logic [LEN_W-1:0]        skip_q, skip_d, skip_dec, seg_len;
	logic [OFFSET_BITS-1:0]  off_q, off_d, trunc_q, trunc_d;
	logic [SEG_CNT_W-1:0]    seen_q, seen_d;
	status_t                 sticky_q, sticky_d, final_status;
	logic                    accept, do_finish;
	logic [ADDR_W-1:0]       fin_fw, fin_sw, word_hi;
	entry_t                  entry;

	assign in_bytes.ready = !q_full;
	assign accept         = in_bytes.valid && !q_full;
	assign word_hi        = {in_bytes.data_byte, sw_q[7:0]};
	assign seg_len        = {1'b0, fin_sw} - {1'b0, fin_fw} + LEN_W'(1);
	assign skip_dec       = (skip_q != '0) ? skip_q - LEN_W'(1) : skip_q;

	always_comb begin
		phase_d      = phase_q;
		hbc_d        = hbc_q;
		fw_d         = fw_q;
		sw_d         = sw_q;
		skip_d       = skip_q;
		off_d        = off_q;
		seen_d       = seen_q;
		sticky_d     = sticky_q;
		trunc_d      = trunc_q;
		do_finish    = 1'b0;
		fin_fw       = fw_q;
		fin_sw       = word_hi;
		final_status = sticky_q;
		entry        = '0;
		entry.status = ST_OK;

		if (accept) begin
			off_d = off_q + OFFSET_BITS'(1);
			case (phase_q)
				PH_HDR: begin
					case (hbc_q)
						2'd0:    fw_d = {8'h00, in_bytes.data_byte};
						2'd1:    fw_d = {in_bytes.data_byte, fw_q[7:0]};
						2'd2:    sw_d = {8'h00, in_bytes.data_byte};
						default: sw_d = word_hi;
					endcase
					hbc_d = hbc_q + 2'd1;
					if (hbc_q == 2'd3) begin
						if (fw_q == MARKER_WORD) begin
							// marker seen: real start word was the second word
							fw_d    = word_hi;
							sw_d    = '0;
							hbc_d   = '0;
							phase_d = PH_EXT;
						end else begin
							do_finish = 1'b1;
						end
					end
				end
				PH_EXT: begin
					if (hbc_q == 2'd0) begin
						sw_d  = {8'h00, in_bytes.data_byte};
						hbc_d = 2'd1;
					end else begin
						sw_d      = word_hi;
						do_finish = 1'b1;
					end
				end
				PH_SKIP: begin
					skip_d = skip_dec;
					if (skip_dec == '0) begin
						phase_d = PH_HDR;
					end
				end
				default: ;
			endcase

			if (do_finish) begin
				hbc_d = '0;
				if (seen_q >= SEG_CNT_W'(MAX_SEGMENTS)) begin
					sticky_d = ST_FULL;
					phase_d  = PH_DONE;
				end else if (fin_fw == PADDING_WORD && fin_sw == PADDING_WORD) begin
					trunc_d  = off_d - PAD_HEADER_BYTES;
					sticky_d = ST_PAD;
					phase_d  = PH_DONE;
				end else if (fin_sw < fin_fw) begin
					sticky_d = ST_RANGE;
					phase_d  = PH_DONE;
				end else begin
					entry.rec_valid = 1'b1;
					entry.seg_index = IDX_W'(seen_q);
					entry.load_addr = fin_fw;
					entry.seg_len   = seg_len;
					entry.data_off  = OFF_W'(off_d);
					seen_d          = seen_q + SEG_CNT_W'(1);
					skip_d          = seg_len;
					phase_d         = PH_SKIP;
				end
			end

			if (in_bytes.is_last_byte) begin
				if (sticky_d == ST_OK &&
				    ((phase_d == PH_HDR && hbc_d != '0) || phase_d == PH_EXT)) begin
					final_status = ST_SHORT;
				end else begin
					final_status = sticky_d;
				end
				entry.stat_valid = 1'b1;
				entry.status     = final_status;
				entry.img_len    = (final_status == ST_PAD) ? OFF_W'(trunc_d) : OFF_W'(off_d);
				entry.seg_count  = COUNT_W'(seen_d);
				// back to the reset state for the next image
				phase_d  = PH_HDR;
				hbc_d    = '0;
				fw_d     = '0;
				sw_d     = '0;
				skip_d   = '0;
				off_d    = '0;
				seen_d   = '0;
				sticky_d = ST_OK;
				trunc_d  = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HDR;
			hbc_q      <= '0;
			fw_q       <= '0;
			sw_q       <= '0;
			skip_q     <= '0;
			off_q      <= '0;
			seen_q     <= '0;
			sticky_q   <= ST_OK;
			trunc_q    <= '0;
		end else begin
			phase_q    <= phase_d;
			hbc_q      <= hbc_d;
			fw_q       <= fw_d;
			sw_q       <= sw_d;
			skip_q     <= skip_d;
			off_q      <= off_d;
			seen_q     <= seen_d;
			sticky_q   <= sticky_d;
			trunc_q    <= trunc_d;
		end
	end

	assign push       = accept && (entry.rec_valid || entry.stat_valid);
	assign push_entry = entry;

endmodule

`default_nettype wire

// ===== rtl/core/eshp_queue.sv =====
// ----------------------------------------------------------------------------
// eshp_queue - front-to-back entry queue
// Small circular FIFO of classified entries.
// ----------------------------------------------------------------------------
`default_nettype none

module eshp_queue (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 push,
	input  wire eshp_pkg::entry_t push_entry,
	input  wire                 pop,
	output logic                full,
	output logic                q_valid,
	output eshp_pkg::entry_t    head_entry
);
	import eshp_pkg::*;

	entry_t              slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;
	logic                do_pop;

	assign full       = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign q_valid    = (count_q != '0);
	assign head_entry = slot_q[rd_ptr_q];
	assign do_pop     = pop && q_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !do_pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (do_pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/eshp_back.sv =====
// ----------------------------------------------------------------------------
// eshp_back - result issue stage
// Expands queue entries into result transactions through an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module eshp_back (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 q_valid,
	input  wire eshp_pkg::entry_t head_entry,
	output logic                pop,
	eshp_result_if.source       results
);
	import eshp_pkg::*;

	logic    out_valid_q;
	logic    pend_q;
	entry_t  pend_entry_q;
	logic    can_load;

	assign can_load      = !out_valid_q || results.ready;
	assign pop           = can_load && !pend_q && q_valid;
	assign results.valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			pend_q      <= 1'b0;
		end else if (can_load) begin
			if (pend_q) begin
				out_valid_q <= 1'b1;
				pend_q      <= 1'b0;
			end else if (q_valid) begin
				out_valid_q <= 1'b1;
				// record goes out first; a status in the same entry waits
				pend_q      <= head_entry.rec_valid && head_entry.stat_valid;
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (can_load) begin
			if (pend_q || (q_valid && !head_entry.rec_valid)) begin
				results.record_kind    <= KIND_STATUS;
				results.segment_index  <= '0;
				results.load_address   <= '0;
				results.segment_length <= '0;
				results.data_offset    <= '0;
				results.parse_status   <= pend_q ? pend_entry_q.status : head_entry.status;
				results.image_length   <= pend_q ? pend_entry_q.img_len : head_entry.img_len;
				results.segment_count  <= pend_q ? pend_entry_q.seg_count
				                                 : head_entry.seg_count;
				results.is_last_result <= 1'b1;
			end else if (q_valid) begin
				results.record_kind    <= KIND_SEGMENT;
				results.segment_index  <= head_entry.seg_index;
				results.load_address   <= head_entry.load_addr;
				results.segment_length <= head_entry.seg_len;
				results.data_offset    <= head_entry.data_off;
				results.parse_status   <= ST_OK;
				results.image_length   <= '0;
				results.segment_count  <= '0;
				results.is_last_result <= 1'b0;
			end
			if (!pend_q && q_valid) begin
				pend_entry_q <= head_entry;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/executable_segment_header_parser_core.sv =====
// ----------------------------------------------------------------------------
// executable_segment_header_parser_core - segment header parser top level
// Streams executable image bytes and reports segment records and a status.
// ----------------------------------------------------------------------------
// The block takes one image byte per clock on in_bytes (valid/ready, last
// flag on the final byte) and parses little-endian start/end headers, with
// an optional 0xFFFF marker word. Each good header yields a segment record
// (index, load address, length, data offset); the data bytes are then
// skipped. The final byte yields a status transaction (ok, padding
// truncation, short header, table full, bad range) with the effective image
// length and segment count, after which the parser is back in its reset
// state for the next image. A header finished by the final byte gives its
// record first, then the status. Throughput: one byte per cycle. The front
// parser is stalled only when the 4-entry queue to the result stage is full;
// a byte carrying both a record and a status gives two transactions from the
// output register, which drains one transaction per cycle while results.ready
// is high, and the parser keeps running meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

module executable_segment_header_parser_core (
	input  wire             clk,
	input  wire             arst_n,
	eshp_byte_if.sink       in_bytes,
	eshp_result_if.source   results
);
	import eshp_pkg::*;

	// front -> queue
	logic    push;
	entry_t  push_entry;
	logic    q_full;

	// queue -> back
	logic    q_valid;
	entry_t  head_entry;
	logic    pop;

	// Header state machine and byte classification
	eshp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_bytes   (in_bytes),
		.q_full     (q_full),
		.push       (push),
		.push_entry (push_entry)
	);

	// Decouples parsing from output back-pressure
	eshp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.full       (q_full),
		.q_valid    (q_valid),
		.head_entry (head_entry)
	);

	// Output register; splits record+status entries into two transactions
	eshp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.head_entry (head_entry),
		.pop        (pop),
		.results    (results)
	);

endmodule

`default_nettype wire
